### sv/ngx_pkg.sv
// Shared constants, request codes and controller/datapath interface types for the NGx block.
`timescale 1ns / 1ps

package ngx_pkg;

   // Store geometry.
   localparam int MAX_CONTIGS = 1024;
   localparam int ADDR_W      = $clog2(MAX_CONTIGS);
   localparam int CNT_W       = $clog2(MAX_CONTIGS + 1);

   // Field widths.
   localparam int REQ_W = 2;
   localparam int LEN_W = 31;
   localparam int PCT_W = 7;
   localparam int GS_W  = 32;

   // Percent arithmetic: thresholds are tested as scale * sum >= percent * genome_size.
   localparam int PERCENT_SCALE = 100;
   localparam int SCALE_W       = $clog2(PERCENT_SCALE + 1);
   localparam int SCALED_W      = LEN_W + SCALE_W;
   localparam int TARGET_W      = PCT_W + GS_W;
   localparam int ACC_W         = SCALED_W + CNT_W;

   // Request codes.
   localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
   localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start_clear;
      logic start_load;
      logic start_query;
      logic start_other;
      logic ins_shift;
      logic ins_place;
      logic qry_step;
      logic rsp_load;
   } ngx_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic full;
      logic idx_zero;
      logic shift_ok;
      logic hit;
      logic exhausted;
   } ngx_sts_type;

endpackage

### sv/ngx_ctrl.sv
// Controller state machine: sequences clear, sorted insertion, query walk and result hand-off.
`timescale 1ns / 1ps

module ngx_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [ngx_pkg::REQ_W-1:0]       req_type,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  ngx_pkg::ngx_sts_type            sts,
   output ngx_pkg::ngx_cmd_type            cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_INS    = 2'd1;
   localparam logic [1:0] ST_QRY    = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_type)
                  ngx_pkg::REQ_CLEAR: begin
                     cmd.start_clear = 1'b1;
                     state_in        = ST_FINISH;
                  end
                  ngx_pkg::REQ_LOAD: begin
                     cmd.start_load = 1'b1;
                     state_in       = sts.full ? ST_FINISH : ST_INS;
                  end
                  ngx_pkg::REQ_QUERY: begin
                     cmd.start_query = 1'b1;
                     state_in        = ST_QRY;
                  end
                  default: begin
                     cmd.start_other = 1'b1;
                     state_in        = ST_FINISH;
                  end
               endcase
            end
         end
         ST_INS: begin
            // Move smaller entries up one place until the new length's slot is found.
            if (!sts.idx_zero && sts.shift_ok) begin
               cmd.ins_shift = 1'b1;
            end else begin
               cmd.ins_place = 1'b1;
               state_in      = ST_FINISH;
            end
         end
         ST_QRY: begin
            cmd.qry_step = 1'b1;
            if (sts.hit || sts.exhausted) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // A finished result with a free output register is presented on the next edge.
   a_finish_hands_off: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) && !rsp_valid_ff |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("finished result was not handed to the output register");

   // An accepted query always starts the walk.
   a_query_starts_walk: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_type == ngx_pkg::REQ_QUERY) |=> (state_ff == ST_QRY))
      else $error("accepted query did not enter the walk");

endmodule

### sv/ngx_dp.sv
// Datapath: sorted length store, insertion shifter, pipelined query accumulator and result registers.
`timescale 1ns / 1ps

module ngx_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [ngx_pkg::LEN_W-1:0]       req_contig_length,
   input  logic [ngx_pkg::PCT_W-1:0]       req_percent,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [ngx_pkg::GS_W-1:0]        csr_genome_size,
   input  ngx_pkg::ngx_cmd_type            cmd,
   output ngx_pkg::ngx_sts_type            sts,
   output logic                            rsp_status,
   output logic                            rsp_found,
   output logic [ngx_pkg::LEN_W-1:0]       rsp_ngx_length,
   output logic [ngx_pkg::PCT_W-1:0]       rsp_query_percent
);

   logic [ngx_pkg::LEN_W-1:0]    mem [ngx_pkg::MAX_CONTIGS];
   logic                         mem_we;
   logic [ngx_pkg::ADDR_W-1:0]   mem_wa;
   logic [ngx_pkg::LEN_W-1:0]    mem_wd;
   logic [ngx_pkg::ADDR_W-1:0]   rd_addr_in;
   logic [ngx_pkg::LEN_W-1:0]    rd_data_ff;

   logic [ngx_pkg::GS_W-1:0]     gs_ff, gs_in;
   logic [ngx_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [ngx_pkg::CNT_W-1:0]    idx_ff, idx_in;
   logic [ngx_pkg::LEN_W-1:0]    len_ff, len_in;
   logic [ngx_pkg::TARGET_W-1:0] target_ff, target_in;
   logic                         v1_ff, v1_in;
   logic                         v2_ff, v2_in;
   logic [ngx_pkg::SCALED_W-1:0] scaled_ff, scaled_in;
   logic [ngx_pkg::LEN_W-1:0]    len2_ff, len2_in;
   logic [ngx_pkg::ACC_W-1:0]    acc_ff, acc_in;

   logic                         res_status_ff, res_status_in;
   logic                         res_found_ff, res_found_in;
   logic [ngx_pkg::LEN_W-1:0]    res_len_ff, res_len_in;
   logic [ngx_pkg::PCT_W-1:0]    res_pct_ff, res_pct_in;
   logic                         rsp_status_ff, rsp_status_in;
   logic                         rsp_found_ff, rsp_found_in;
   logic [ngx_pkg::LEN_W-1:0]    rsp_len_ff, rsp_len_in;
   logic [ngx_pkg::PCT_W-1:0]    rsp_pct_ff, rsp_pct_in;

   logic [ngx_pkg::CNT_W-1:0]    count_m1;
   logic [ngx_pkg::CNT_W-1:0]    idx_m2;
   logic [ngx_pkg::ACC_W-1:0]    acc_sum;
   logic                         idx_below;
   logic                         start_any;

   assign count_m1  = count_ff - ngx_pkg::CNT_W'(1);
   assign idx_m2    = idx_ff - ngx_pkg::CNT_W'(2);
   assign acc_sum   = acc_ff + ngx_pkg::ACC_W'(scaled_ff);
   assign idx_below = (idx_ff < count_ff);
   assign start_any = cmd.start_clear || cmd.start_load || cmd.start_query || cmd.start_other;

   assign sts.full      = (count_ff == ngx_pkg::CNT_W'(ngx_pkg::MAX_CONTIGS));
   assign sts.idx_zero  = (idx_ff == '0);
   assign sts.shift_ok  = (rd_data_ff < len_ff);
   assign sts.hit       = v2_ff && (acc_sum >= ngx_pkg::ACC_W'(target_ff));
   assign sts.exhausted = !idx_below && !v1_ff && !v2_ff;

   always_comb begin
      gs_in         = gs_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      len_in        = len_ff;
      target_in     = target_ff;
      v1_in         = v1_ff;
      v2_in         = v2_ff;
      scaled_in     = scaled_ff;
      len2_in       = len2_ff;
      acc_in        = acc_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_len_in    = res_len_ff;
      res_pct_in    = res_pct_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_pct_in    = rsp_pct_ff;
      mem_we        = 1'b0;
      mem_wa        = idx_ff[ngx_pkg::ADDR_W-1:0];
      mem_wd        = len_ff;
      rd_addr_in    = idx_ff[ngx_pkg::ADDR_W-1:0];

      if (csr_valid && csr_ready) begin
         gs_in = csr_genome_size;
      end

      if (start_any) begin
         res_status_in = cmd.start_load && sts.full;
         res_found_in  = 1'b0;
         res_len_in    = '0;
         res_pct_in    = cmd.start_query ? req_percent : '0;
      end

      if (cmd.start_clear) begin
         count_in = '0;
      end

      if (cmd.start_load) begin
         // Insertion works downwards from the first free slot.
         len_in     = req_contig_length;
         idx_in     = count_ff;
         rd_addr_in = count_m1[ngx_pkg::ADDR_W-1:0];
      end

      if (cmd.start_query) begin
         target_in  = ngx_pkg::TARGET_W'(req_percent) * ngx_pkg::TARGET_W'(gs_ff);
         acc_in     = '0;
         idx_in     = ngx_pkg::CNT_W'(1);
         rd_addr_in = '0;
         v1_in      = (count_ff != '0);
         v2_in      = 1'b0;
      end

      if (cmd.ins_shift) begin
         mem_we     = 1'b1;
         mem_wd     = rd_data_ff;
         idx_in     = idx_ff - ngx_pkg::CNT_W'(1);
         rd_addr_in = idx_m2[ngx_pkg::ADDR_W-1:0];
      end

      if (cmd.ins_place) begin
         mem_we   = 1'b1;
         mem_wd   = len_ff;
         count_in = count_ff + ngx_pkg::CNT_W'(1);
      end

      if (cmd.qry_step) begin
         // Read, scale, then accumulate and compare: one entry per cycle.
         v1_in     = idx_below;
         if (idx_below) begin
            idx_in = idx_ff + ngx_pkg::CNT_W'(1);
         end
         v2_in     = v1_ff;
         scaled_in = ngx_pkg::SCALED_W'(rd_data_ff)
                     * ngx_pkg::SCALED_W'(ngx_pkg::PERCENT_SCALE);
         len2_in   = rd_data_ff;
         if (v2_ff) begin
            acc_in = acc_sum;
         end
         if (sts.hit) begin
            res_found_in = 1'b1;
            res_len_in   = len2_ff;
         end
      end

      if (cmd.rsp_load) begin
         rsp_status_in = res_status_ff;
         rsp_found_in  = res_found_ff;
         rsp_len_in    = res_len_ff;
         rsp_pct_in    = res_pct_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[rd_addr_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gs_ff    <= '0;
         count_ff <= '0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
      end else begin
         gs_ff    <= gs_in;
         count_ff <= count_in;
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      len_ff        <= len_in;
      target_ff     <= target_in;
      scaled_ff     <= scaled_in;
      len2_ff       <= len2_in;
      acc_ff        <= acc_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_len_ff    <= res_len_in;
      res_pct_ff    <= res_pct_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_pct_ff    <= rsp_pct_in;
   end

   assign rsp_status        = rsp_status_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_ngx_length    = rsp_len_ff;
   assign rsp_query_percent = rsp_pct_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ngx_pkg::CNT_W'(ngx_pkg::MAX_CONTIGS))
      else $error("entry count exceeds the store depth");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.start_clear |=> (count_ff == '0))
      else $error("clear did not empty the store");

   a_place_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.ins_place |-> (idx_ff <= count_ff) && !sts.full)
      else $error("insertion slot lies beyond the filled entries");

endmodule

### sv/ngx_contig_statistic.sv
// Top level of the NGx contiguity statistic block: controller plus datapath.
`timescale 1ns / 1ps

// The block keeps up to 1024 contig lengths in descending order and answers NGx queries.
// Requests arrive as beats on the req_ channel (req_valid / req_stall): a clear empties the
// store, a load inserts one length at its sorted place, and a query for percent x returns
// the first length whose running sum satisfies 100 * sum >= x * genome_size.
// Every request beat produces exactly one beat on the rsp_ channel (rsp_valid / rsp_stall).
// The genome size is written through the csr_ channel, which is always ready; it must only
// be written while no request is outstanding.
// Work is done one request at a time. A clear goes straight to the finishing state. A
// load moves each stored entry smaller than the new length up one place through the
// insertion shifter, one entry at a time, then places the new length. A query walks the
// store at one entry per cycle through a three-stage read, scale and accumulate pipeline.
// The one read port of the length memory sets the pace of the shifter and of the walk.
// The result sits in an output register, so a new request is taken while the previous
// result beat waits; if the receiver keeps rsp_stall high, the block holds the finished
// result internally and raises req_stall until the output register frees.
// A synchronous reset empties the store, clears the genome size and drops rsp_valid.

module ngx_contig_statistic (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [ngx_pkg::REQ_W-1:0]       req_type,
   input  logic [ngx_pkg::LEN_W-1:0]       req_contig_length,
   input  logic [ngx_pkg::PCT_W-1:0]       req_percent,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_status,
   output logic                            rsp_found,
   output logic [ngx_pkg::LEN_W-1:0]       rsp_ngx_length,
   output logic [ngx_pkg::PCT_W-1:0]       rsp_query_percent,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ngx_pkg::GS_W-1:0]        csr_genome_size
);

   ngx_pkg::ngx_cmd_type cmd;
   ngx_pkg::ngx_sts_type sts;

   // Users must issue register writes only while the block is idle; it does not enforce this.
   assign csr_ready = 1'b1;

   ngx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_type  (req_type),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ngx_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_contig_length (req_contig_length),
      .req_percent       (req_percent),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_genome_size   (csr_genome_size),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_status        (rsp_status),
      .rsp_found         (rsp_found),
      .rsp_ngx_length    (rsp_ngx_length),
      .rsp_query_percent (rsp_query_percent)
   );

endmodule

### bench/tb.sv
// Self-checking testbench for the NGx contiguity statistic block.
`timescale 1ns / 1ps

// The bench drives request beats into the block and keeps its own copy of the contig store.
// That copy is a descending array of lengths with an entry count, plus the genome size
// register. It works out the answer to every accepted request beat and queues it. A
// checker process pops the oldest queued answer for every accepted result beat and
// compares it field by field.
//
// The run is built from named tests that are called in turn. Directed tests come first:
// the reset value of the genome size, the empty store, the spare request code, sorted
// insertion with duplicates and zero lengths, percent zero, one hundred and above, and
// lengths at the top of their range. Random blocks follow, made of well-formed
// clear/load/query sequences sprinkled with noise, under three idling mixes and a range
// of genome sizes. There is also a back-pressure test in which the receiver holds off for
// a long stretch.
module tb;

   // The one request code the package does not name: the block must answer it with zeros.
   localparam logic [ngx_pkg::REQ_W-1:0] REQ_SPARE = 2'd3;

   localparam logic [ngx_pkg::LEN_W-1:0] LEN_MAX      = '1;
   localparam logic [ngx_pkg::GS_W-1:0]  GENOME_MAX   = '1;
   localparam int                        LIMIT_CYCLES = 4_000_000;
   // Long enough to walk a full store, so this covers any straggler.
   localparam int                        TAIL_CYCLES  = ngx_pkg::MAX_CONTIGS + 100;
   localparam int                        SHOWN_ERRORS = 10;

   typedef struct packed {
      logic                      status;
      logic                      found;
      logic [ngx_pkg::LEN_W-1:0] ngx_length;
      logic [ngx_pkg::PCT_W-1:0] query_percent;
   } ngx_answer_type;

   logic                      clock;
   logic                      reset             = 1'b1;
   logic                      req_valid         = 1'b0;
   logic                      req_stall;
   logic [ngx_pkg::REQ_W-1:0] req_type          = ngx_pkg::REQ_CLEAR;
   logic [ngx_pkg::LEN_W-1:0] req_contig_length = '0;
   logic [ngx_pkg::PCT_W-1:0] req_percent       = '0;
   logic                      rsp_valid;
   logic                      rsp_stall         = 1'b0;
   logic                      rsp_status;
   logic                      rsp_found;
   logic [ngx_pkg::LEN_W-1:0] rsp_ngx_length;
   logic [ngx_pkg::PCT_W-1:0] rsp_query_percent;
   logic                      csr_valid         = 1'b0;
   logic                      csr_ready;
   logic [ngx_pkg::GS_W-1:0]  csr_genome_size   = '0;

   // The bench's own copy of the store and of the genome size register.
   logic [ngx_pkg::LEN_W-1:0] shadow_lengths [ngx_pkg::MAX_CONTIGS];
   int                        shadow_count  = 0;
   logic [ngx_pkg::GS_W-1:0]  shadow_genome = '0;

   ngx_answer_type   pending_answers [$];

   int send_idle_pct   = 16;
   int recv_idle_pct   = 77;
   int hold_left       = 0;
   int cycle_count     = 0;
   int mismatch_count  = 0;
   int beats_checked   = 0;
   int counted_beats   = 0;
   int loads_dropped   = 0;
   int queries_found   = 0;
   int queries_missed  = 0;
   int genome_writes   = 0;

   ngx_contig_statistic DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_contig_length (req_contig_length),
      .req_percent       (req_percent),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_found         (rsp_found),
      .rsp_ngx_length    (rsp_ngx_length),
      .rsp_query_percent (rsp_query_percent),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_genome_size   (csr_genome_size)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The cycle counter ends a run that hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Timed out after %0d cycles with %0d answers outstanding",
                  cycle_count, pending_answers.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // Applies one request to the bench's copy of the store and returns the answer it gives.
   // A load walks past every stored length that is greater or equal, so equal lengths
   // keep their arrival order. A query compares scaled running sums in 64 bits, which
   // cannot overflow at this depth.
   function automatic ngx_answer_type predict_answer(input logic [ngx_pkg::REQ_W-1:0] kind,
                                                     input logic [ngx_pkg::LEN_W-1:0] len,
                                                     input logic [ngx_pkg::PCT_W-1:0] pct);
      ngx_answer_type ans;
      logic [63:0]    threshold;
      logic [63:0]    running;
      int             pos;
      ans = '0;
      case (kind)
         ngx_pkg::REQ_CLEAR: begin
            shadow_count = 0;
         end
         ngx_pkg::REQ_LOAD: begin
            if (shadow_count >= ngx_pkg::MAX_CONTIGS) begin
               ans.status = 1'b1;
            end else begin
               pos = 0;
               while (pos < shadow_count && shadow_lengths[pos] >= len) pos++;
               for (int k = shadow_count; k > pos; k--) shadow_lengths[k] = shadow_lengths[k-1];
               shadow_lengths[pos] = len;
               shadow_count++;
            end
         end
         ngx_pkg::REQ_QUERY: begin
            threshold         = 64'(pct) * 64'(shadow_genome);
            running           = '0;
            ans.query_percent = pct;
            for (int i = 0; i < shadow_count && !ans.found; i++) begin
               running += 64'(shadow_lengths[i]);
               if (64'(ngx_pkg::PERCENT_SCALE) * running >= threshold) begin
                  ans.found      = 1'b1;
                  ans.ngx_length = shadow_lengths[i];
               end
            end
         end
         default: ;
      endcase
      return ans;
   endfunction

   task automatic note_mismatch(input string what, input ngx_answer_type want,
                                input ngx_answer_type got);
      mismatch_count++;
      if (mismatch_count <= SHOWN_ERRORS) begin
         $display("%0t: %s: expected status %0d found %0d length %0d percent %0d,",
                  $realtime, what, want.status, want.found, want.ngx_length,
                  want.query_percent);
         $display("   got status %0d found %0d length %0d percent %0d",
                  got.status, got.found, got.ngx_length, got.query_percent);
      end
   endtask

   // The receiver. It checks every accepted result beat against the oldest queued answer.
   // It then decides the stall for the next cycle: either a long hold-off that a test has
   // asked for, or random idling.
   always @(posedge clock) begin
      ngx_answer_type want;
      ngx_answer_type got;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            beats_checked++;
            got = '{rsp_status, rsp_found, rsp_ngx_length, rsp_query_percent};
            if (pending_answers.size() == 0) begin
               note_mismatch("Result beat with no request outstanding", '0, got);
            end else begin
               want = pending_answers.pop_front();
               if (got.status !== want.status || got.found !== want.found ||
                   got.ngx_length !== want.ngx_length ||
                   got.query_percent !== want.query_percent)
                  note_mismatch("Result beat differs", want, got);
            end
         end
         rsp_stall <= (hold_left > 0) || ($urandom_range(99) < recv_idle_pct);
         if (hold_left > 0) hold_left--;
      end
   end

   // Offers one request beat, after a random gap, and holds it until the block takes it.
   // The answer is worked out at the edge of acceptance, since the block serves requests
   // in the order it accepts them.
   task automatic send_request(input logic [ngx_pkg::REQ_W-1:0] kind,
                               input logic [ngx_pkg::LEN_W-1:0] len,
                               input logic [ngx_pkg::PCT_W-1:0] pct);
      ngx_answer_type ans;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_type          <= kind;
      req_contig_length <= len;
      req_percent       <= pct;
      do @(posedge clock); while (req_stall);
      ans = predict_answer(kind, len, pct);
      pending_answers = {pending_answers, ans};
      if (kind != REQ_SPARE) counted_beats++;
      if (ans.status) loads_dropped++;
      if (kind == ngx_pkg::REQ_QUERY) begin
         if (ans.found) queries_found++;
         else queries_missed++;
      end
   endtask

   // The sender pauses until every answer it is owed has come back.
   task automatic wait_for_answers();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_answers.size() != 0);
   endtask

   // The genome size may only change while nothing is outstanding.
   task automatic write_genome_size(input logic [ngx_pkg::GS_W-1:0] value);
      wait_for_answers();
      csr_valid       <= 1'b1;
      csr_genome_size <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid     <= 1'b0;
      shadow_genome = value;
      genome_writes++;
   endtask

   // Straight after reset the genome size is zero. A query on an empty store still echoes
   // its percent, the spare code answers with zeros, and a single contig answers any query.
   task automatic test_reset_state();
      send_request(ngx_pkg::REQ_QUERY, '0, 7'd100);
      send_request(REQ_SPARE, LEN_MAX, '1);
      send_request(ngx_pkg::REQ_CLEAR, '0, '0);
      send_request(ngx_pkg::REQ_LOAD, 31'd7, '0);
      send_request(ngx_pkg::REQ_QUERY, '0, 7'd50);
   endtask

   // Duplicates and a zero length must land at their sorted places. Queries at 0 and 50
   // percent stop at the first entry, at 80 at the second, at 100 and 110 at the third. At
   // 127 percent the total falls short, so that query is not found.
   task automatic test_sorted_insert();
      write_genome_size(32'd1000);
      send_request(ngx_pkg::REQ_CLEAR, '0, '0);
      send_request(ngx_pkg::REQ_LOAD, 31'd300, '0);
      send_request(ngx_pkg::REQ_LOAD, 31'd500, '0);
      send_request(ngx_pkg::REQ_LOAD, 31'd0, '0);
      send_request(ngx_pkg::REQ_LOAD, 31'd300, '0);
      send_request(ngx_pkg::REQ_QUERY, '0, 7'd0);
      send_request(ngx_pkg::REQ_QUERY, '0, 7'd50);
      send_request(ngx_pkg::REQ_QUERY, '0, 7'd80);
      send_request(ngx_pkg::REQ_QUERY, '0, 7'd100);
      send_request(ngx_pkg::REQ_QUERY, '0, 7'd110);
      send_request(ngx_pkg::REQ_QUERY, '0, 7'd127);
   endtask

   // Two maximum lengths fall one base short of the largest genome size, so the third
   // entry, a single base, is the one that reaches it. Any wrap in the accumulator shows.
   task automatic test_extreme_lengths();
      write_genome_size(GENOME_MAX);
      send_request(ngx_pkg::REQ_CLEAR, '0, '0);
      send_request(ngx_pkg::REQ_LOAD, LEN_MAX, '0);
      send_request(ngx_pkg::REQ_LOAD, 31'd1, '0);
      send_request(ngx_pkg::REQ_LOAD, LEN_MAX, '0);
      send_request(ngx_pkg::REQ_QUERY, '0, 7'd100);
      send_request(ngx_pkg::REQ_QUERY, '0, 7'd127);
      send_request(ngx_pkg::REQ_QUERY, '0, 7'd0);
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering beats
   // without a gap. The output register and the held result fill, and req_stall must rise
   // without any beat being lost or repeated.
   task automatic test_output_backpressure();
      int saved_idle;
      saved_idle    = send_idle_pct;
      send_idle_pct = 0;
      hold_left     = 300;
      send_request(ngx_pkg::REQ_CLEAR, '0, '0);
      for (int i = 0; i < 4; i++)
         send_request(ngx_pkg::REQ_LOAD, ngx_pkg::LEN_W'($urandom), '0);
      for (int i = 0; i < 6; i++)
         send_request(ngx_pkg::REQ_QUERY, '0, ngx_pkg::PCT_W'($urandom_range(0, 127)));
      send_idle_pct = saved_idle;
      wait_for_answers();
   endtask

   // Mostly well-formed sequences: a clear, a run of loads, then a few queries. The lengths
   // are drawn at a random bit width so that their sums fall on both sides of the
   // threshold. About one pick in ten is a stray beat of any code instead. The clear is
   // sometimes left out, which lets the store grow across sequences, up to a bound that
   // keeps the walks short.
   task automatic run_random_block(input int goal);
      int                        stop;
      int                        loads;
      int                        queries;
      int                        width;
      logic [ngx_pkg::LEN_W-1:0] len_mask;
      logic [ngx_pkg::REQ_W-1:0] kind;
      stop = counted_beats + goal;
      while (counted_beats < stop) begin
         if ($urandom_range(99) < 10) begin
            kind = ngx_pkg::REQ_W'($urandom_range(0, 3));
            send_request(kind, ngx_pkg::LEN_W'($urandom), ngx_pkg::PCT_W'($urandom));
         end else begin
            if ($urandom_range(99) < 85 || shadow_count > 150)
               send_request(ngx_pkg::REQ_CLEAR, ngx_pkg::LEN_W'($urandom),
                            ngx_pkg::PCT_W'($urandom));
            loads    = $urandom_range(1, 24);
            width    = ($urandom_range(99) < 20) ? ngx_pkg::LEN_W
                                                 : $urandom_range(1, ngx_pkg::LEN_W);
            len_mask = ngx_pkg::LEN_W'((64'd1 << width) - 1);
            for (int i = 0; i < loads; i++)
               send_request(ngx_pkg::REQ_LOAD, ngx_pkg::LEN_W'($urandom) & len_mask,
                            ngx_pkg::PCT_W'($urandom));
            queries = $urandom_range(1, 6);
            for (int i = 0; i < queries; i++)
               send_request(ngx_pkg::REQ_QUERY, ngx_pkg::LEN_W'($urandom),
                            ($urandom_range(99) < 70)
                               ? ngx_pkg::PCT_W'($urandom_range(0, 100))
                               : ngx_pkg::PCT_W'($urandom_range(0, 127)));
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_sorted_insert();
      test_extreme_lengths();

      // Sender idles a little and the receiver a lot.
      write_genome_size(GENOME_MAX);
      run_random_block(80);
      test_output_backpressure();
      write_genome_size($urandom >> $urandom_range(0, 31));
      run_random_block(80);

      // Now the other way round.
      send_idle_pct = 77;
      recv_idle_pct = 16;
      write_genome_size(32'd1);
      run_random_block(80);
      write_genome_size($urandom >> $urandom_range(0, 31));
      run_random_block(80);

      // No idling at all.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_genome_size('0);
      run_random_block(80);
      write_genome_size($urandom >> $urandom_range(0, 31));
      run_random_block(80);

      wait_for_answers();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Checked %0d result beats over %0d genome sizes and three idling mixes.",
               beats_checked, genome_writes);
      $display("Queries found %0d, not found %0d; loads dropped on a full store %0d.",
               queries_found, queries_missed, loads_dropped);
      if (mismatch_count == 0 && pending_answers.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d mismatches, %0d answers never arrived",
                  mismatch_count, pending_answers.size());
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

### sim.f
sv/ngx_pkg.sv
sv/ngx_ctrl.sv
sv/ngx_dp.sv
sv/ngx_contig_statistic.sv
bench/tb.sv
